// ===== design/simplex_gradient_noise_2d_macros.svh =====
// assertion macros for the 2d gradient noise block
// included by the top level, no other dependencies
`ifndef SIMPLEX_GRADIENT_NOISE_2D_MACROS_SVH
`define SIMPLEX_GRADIENT_NOISE_2D_MACROS_SVH
`ifndef SYNTH
`define SGN_ASSERT(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
`define SGN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);
`else
`define SGN_ASSERT(label, clk, rst_n, prop, msg)
`define SGN_ASSERT_IMP(label, clk, rst_n, ante, cons, msg)
`endif
`endif

// ===== design/sgn2d_pkg.sv =====
// constants, gradient table and types for the 2d gradient noise block
// no dependencies
`timescale 1ns / 1ps
`default_nettype none
package sgn2d_pkg;

  localparam logic [63:0] PRIME_X  = 64'h5205402B9270C86F;
  localparam logic [63:0] PRIME_Y  = 64'h598CD327003817B5;
  localparam logic [63:0] HASH_MUL = 64'h53A3F72DEEC546F5;

  // q24 constants
  localparam logic signed [24:0] SKEW_Q       = 25'sd6140887;
  localparam logic signed [24:0] ROOT2_HALF_Q = 25'sd11863283;
  localparam logic signed [23:0] UNSKEW_Q     = -24'sd3545443;
  localparam int                 Q_BITS       = 24;
  // offsets of the far and side corners
  localparam logic signed [27:0] DIAG_Q       = 28'sd9686330;
  localparam logic signed [27:0] SIDE_FAR_Q   = 28'sd13231773;
  localparam logic signed [27:0] SIDE_NEAR_Q  = 28'sd3545443;

  localparam logic signed [17:0] OUT_MAX = 18'sd65536;

  typedef struct packed {
    logic signed [23:0] gx;
    logic signed [23:0] gy;
  } grad_t;

  // 24 directions 15 degrees apart, q7.16
  function automatic grad_t grad_lookup(input logic [4:0] idx);
    grad_t g;
    unique case (idx)
      5'd0:  g = '{ 24'sd2503863,  24'sd6044859};
      5'd1:  g = '{ 24'sd6044859,  24'sd2503863};
      5'd2:  g = '{ 24'sd6044859, -24'sd2503863};
      5'd3:  g = '{ 24'sd2503863, -24'sd6044859};
      5'd4:  g = '{-24'sd2503863, -24'sd6044859};
      5'd5:  g = '{-24'sd6044859, -24'sd2503863};
      5'd6:  g = '{-24'sd6044859,  24'sd2503863};
      5'd7:  g = '{-24'sd2503863,  24'sd6044859};
      5'd8:  g = '{ 24'sd854021,   24'sd6486933};
      5'd9:  g = '{ 24'sd3983070,  24'sd5190838};
      5'd10: g = '{ 24'sd5190838,  24'sd3983070};
      5'd11: g = '{ 24'sd6486933,  24'sd854021};
      5'd12: g = '{ 24'sd6486933, -24'sd854021};
      5'd13: g = '{ 24'sd5190838, -24'sd3983070};
      5'd14: g = '{ 24'sd3983070, -24'sd5190838};
      5'd15: g = '{ 24'sd854021,  -24'sd6486933};
      5'd16: g = '{-24'sd854021,  -24'sd6486933};
      5'd17: g = '{-24'sd3983070, -24'sd5190838};
      5'd18: g = '{-24'sd5190838, -24'sd3983070};
      5'd19: g = '{-24'sd6486933, -24'sd854021};
      5'd20: g = '{-24'sd6486933,  24'sd854021};
      5'd21: g = '{-24'sd5190838,  24'sd3983070};
      5'd22: g = '{-24'sd3983070,  24'sd5190838};
      5'd23: g = '{-24'sd854021,   24'sd6486933};
      default: g = '{24'sd0, 24'sd0};
    endcase
    return g;
  endfunction

endpackage
`default_nettype wire

// ===== design/simplex_gradient_noise_2d.sv =====
// top level of the 2d gradient noise block: a twelve stage pipeline
// depends on sgn2d_pkg and simplex_gradient_noise_2d_macros.svh
`timescale 1ns / 1ps
`default_nettype none
`include "simplex_gradient_noise_2d_macros.svh"
// Gradient noise on a skewed triangular lattice. Each request carries one point
// (signed fixed point coordinates with FRACTION_BITS fraction bits) and a kind
// bit: 0 gives 2d noise of x and y, 1 gives 1d noise of x alone (x is scaled onto
// the lattice diagonal). The answer is one signed q1.16 sample, saturated to
// plus or minus 1.0. The block is a twelve stage pipeline: one request per cycle
// is taken while in_ready is high, and each result is registered in the last
// stage and held there until out_ready takes it. Every stage holds its own
// valid bit and only stalls while it and all stages behind it are full, so
// bubbles are squeezed out and in_ready only drops when the whole pipe is full
// and out_ready is low. The three lattice corners are worked in parallel lanes;
// the 64-bit wrapping hash multiplies are split into 32-bit partial products.
// The seed is written through cfg_we / cfg_noise_seed and must only change
// while the pipe is empty. GRADIENT_COUNT picks how many hash bits select a
// gradient (rounded down to a power of two, clamped to 32..1024).
module simplex_gradient_noise_2d #(
  parameter int GRADIENT_COUNT = 128,
  parameter int FRACTION_BITS  = 16
) (
  input  wire                clk,
  input  wire                rst_n,
  input  wire                cfg_we,
  input  wire  [63:0]        cfg_noise_seed,
  input  wire                in_valid,
  output logic               in_ready,
  input  wire                in_kind,
  input  wire  signed [31:0] in_coord_x,
  input  wire  signed [31:0] in_coord_y,
  output logic               out_valid,
  input  wire                out_ready,
  output logic signed [17:0] out_noise_value
);

  // gradient select bits and hash shift
  localparam int GB_RAW = $clog2(GRADIENT_COUNT + 1) - 1;
  localparam int GB     = (GB_RAW < 5) ? 5 : ((GB_RAW > 10) ? 10 : GB_RAW);
  localparam int SH     = 65 - GB;
  localparam int UPSH   = sgn2d_pkg::Q_BITS - FRACTION_BITS;
  localparam int NST    = 12;
  localparam int PW     = 58;  // first product
  localparam int XW     = 50;  // skewed coordinates, q24
  localparam int BW     = XW - 24;  // lattice cell index
  localparam int DW     = 28;  // corner offsets, q3.24
  localparam int TW     = 50;  // unskew product
  localparam int GW     = 52;  // gradient products
  localparam int OW     = 36;  // dot product, q24
  localparam longint RND_F = 64'sd1 <<< (FRACTION_BITS - 1);

  // pipeline control
  logic [NST:1] v_r;
  logic [NST:1] en;

  for (genvar k = 1; k <= NST; k++) begin : g_en
    assign en[k] = ~((&v_r[NST:k]) & ~out_ready);
  end

  assign in_ready  = en[1];
  assign out_valid = v_r[NST];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      if (en[1]) begin
        v_r[1] <= in_valid;
      end
      for (int k = 2; k <= NST; k++) begin
        if (en[k]) begin
          v_r[k] <= v_r[k-1];
        end
      end
    end
  end

  // seed register
  logic [63:0] seed_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      seed_r <= '0;
    end else if (cfg_we) begin
      seed_r <= cfg_noise_seed;
    end
  end

  // stage 1: skew or diagonal scale product
  logic                  s1_kind_r;
  logic signed [31:0]    s1_x_r, s1_y_r;
  logic signed [PW-1:0]  s1_prod_r;
  logic signed [32:0]    mul_a;
  logic signed [24:0]    mul_c;

  always_comb begin
    if (in_kind) begin
      mul_a = {in_coord_x[31], in_coord_x};
      mul_c = sgn2d_pkg::ROOT2_HALF_Q;
    end else begin
      mul_a = 33'(in_coord_x) + 33'(in_coord_y);
      mul_c = sgn2d_pkg::SKEW_Q;
    end
  end

  always_ff @(posedge clk) begin
    if (en[1]) begin
      s1_kind_r <= in_kind;
      s1_x_r    <= in_coord_x;
      s1_y_r    <= in_coord_y;
      s1_prod_r <= PW'(mul_a * mul_c);
    end
  end

  // stage 2: skewed point in q24
  logic signed [XW-1:0] s2_xs_r, s2_ys_r;
  logic signed [PW-1:0] s1_rsum;
  logic signed [XW-1:0] s1_rnd, s1_xu, s1_yu;

  always_comb begin
    s1_rsum = s1_prod_r + PW'(RND_F);
    s1_rnd  = XW'(s1_rsum >>> FRACTION_BITS);
    s1_xu   = XW'(s1_x_r) <<< UPSH;
    s1_yu   = XW'(s1_y_r) <<< UPSH;
  end

  always_ff @(posedge clk) begin
    if (en[2]) begin
      if (s1_kind_r) begin
        s2_xs_r <= s1_rnd;
        s2_ys_r <= -s1_rnd;
      end else begin
        s2_xs_r <= s1_xu + s1_rnd;
        s2_ys_r <= s1_yu + s1_rnd;
      end
    end
  end

  // stage 3: floor to cell, unskew product, cell hash partial products
  logic [23:0]          s3_xi_r, s3_yi_r;
  logic signed [TW-1:0] s3_t_r;
  logic [63:0]          s3_xpl_r, s3_ypl_r;
  logic [31:0]          s3_xph_r, s3_yph_r;
  logic signed [BW-1:0] s2_xb, s2_yb;
  logic [24:0]          s2_isum;

  always_comb begin
    s2_xb   = s2_xs_r[XW-1:24];
    s2_yb   = s2_ys_r[XW-1:24];
    s2_isum = 25'(s2_xs_r[23:0]) + 25'(s2_ys_r[23:0]);
  end

  always_ff @(posedge clk) begin
    if (en[3]) begin
      s3_xi_r  <= s2_xs_r[23:0];
      s3_yi_r  <= s2_ys_r[23:0];
      s3_t_r   <= TW'($signed({1'b0, s2_isum}) * sgn2d_pkg::UNSKEW_Q);
      s3_xpl_r <= 64'(s2_xb * $signed({1'b0, sgn2d_pkg::PRIME_X[31:0]}));
      s3_xph_r <= 32'(s2_xb * $signed({1'b0, sgn2d_pkg::PRIME_X[63:32]}));
      s3_ypl_r <= 64'(s2_yb * $signed({1'b0, sgn2d_pkg::PRIME_Y[31:0]}));
      s3_yph_r <= 32'(s2_yb * $signed({1'b0, sgn2d_pkg::PRIME_Y[63:32]}));
    end
  end

  // stage 4: first corner offset and cell hashes
  logic signed [DW-1:0] s4_dx0_r, s4_dy0_r;
  logic [63:0]          s4_xp_r, s4_yp_r;
  logic signed [TW-1:0] s3_tsum;
  logic signed [DW-1:0] s3_t;

  always_comb begin
    s3_tsum = s3_t_r + TW'(64'sd1 <<< 23);
    s3_t    = DW'(s3_tsum >>> 24);
  end

  always_ff @(posedge clk) begin
    if (en[4]) begin
      s4_dx0_r <= $signed(DW'(s3_xi_r)) + s3_t;
      s4_dy0_r <= $signed(DW'(s3_yi_r)) + s3_t;
      s4_xp_r  <= s3_xpl_r + {s3_xph_r, 32'h0};
      s4_yp_r  <= s3_ypl_r + {s3_yph_r, 32'h0};
    end
  end

  // stage 5: three corner lanes, offsets and hash keys
  logic signed [DW-1:0] s5_dx_r [3];
  logic signed [DW-1:0] s5_dy_r [3];
  logic [63:0]          s5_key_r [3];
  logic [63:0]          s4_xp1, s4_yp1;

  always_comb begin
    s4_xp1 = s4_xp_r + sgn2d_pkg::PRIME_X;
    s4_yp1 = s4_yp_r + sgn2d_pkg::PRIME_Y;
  end

  always_ff @(posedge clk) begin
    if (en[5]) begin
      s5_dx_r[0]  <= s4_dx0_r;
      s5_dy_r[0]  <= s4_dy0_r;
      s5_key_r[0] <= seed_r ^ s4_xp_r ^ s4_yp_r;
      s5_dx_r[1]  <= s4_dx0_r - sgn2d_pkg::DIAG_Q;
      s5_dy_r[1]  <= s4_dy0_r - sgn2d_pkg::DIAG_Q;
      s5_key_r[1] <= seed_r ^ s4_xp1 ^ s4_yp1;
      // third corner sits on the side of the larger offset
      if (s4_dy0_r > s4_dx0_r) begin
        s5_dx_r[2]  <= s4_dx0_r + sgn2d_pkg::SIDE_NEAR_Q;
        s5_dy_r[2]  <= s4_dy0_r - sgn2d_pkg::SIDE_FAR_Q;
        s5_key_r[2] <= seed_r ^ s4_xp_r ^ s4_yp1;
      end else begin
        s5_dx_r[2]  <= s4_dx0_r - sgn2d_pkg::SIDE_FAR_Q;
        s5_dy_r[2]  <= s4_dy0_r + sgn2d_pkg::SIDE_NEAR_Q;
        s5_key_r[2] <= seed_r ^ s4_xp1 ^ s4_yp_r;
      end
    end
  end

  // stage 6: squared offsets and hash partial products
  logic signed [DW-1:0]   s6_dx_r [3];
  logic signed [DW-1:0]   s6_dy_r [3];
  logic signed [2*DW-1:0] s6_dxx_r [3];
  logic signed [2*DW-1:0] s6_dyy_r [3];
  logic [63:0]            s6_hll_r [3];
  logic [31:0]            s6_hlh_r [3];
  logic [31:0]            s6_hhl_r [3];

  always_ff @(posedge clk) begin
    if (en[6]) begin
      for (int c = 0; c < 3; c++) begin
        s6_dx_r[c]  <= s5_dx_r[c];
        s6_dy_r[c]  <= s5_dy_r[c];
        s6_dxx_r[c] <= s5_dx_r[c] * s5_dx_r[c];
        s6_dyy_r[c] <= s5_dy_r[c] * s5_dy_r[c];
        s6_hll_r[c] <= 64'(s5_key_r[c][31:0]) * 64'(sgn2d_pkg::HASH_MUL[31:0]);
        s6_hlh_r[c] <= s5_key_r[c][31:0] * sgn2d_pkg::HASH_MUL[63:32];
        s6_hhl_r[c] <= s5_key_r[c][63:32] * sgn2d_pkg::HASH_MUL[31:0];
      end
    end
  end

  // stage 7: falloff and gradient pair index
  logic signed [DW-1:0] s7_dx_r [3];
  logic signed [DW-1:0] s7_dy_r [3];
  logic [2:0]           s7_apos_r;
  logic [23:0]          s7_a_r [3];
  logic [GB-1:0]        s7_pair_r [3];
  logic signed [33:0]   s6_a [3];
  logic [63:0]          s6_h [3];
  logic [63:0]          s6_hx [3];
  logic signed [2*DW-1:0] s6_sx [3];
  logic signed [2*DW-1:0] s6_sy [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s6_sx[c] = s6_dxx_r[c] + (2*DW)'(64'sd1 <<< 23);
      s6_sy[c] = s6_dyy_r[c] + (2*DW)'(64'sd1 <<< 23);
      s6_a[c]  = 34'sd8388608 - 34'(s6_sx[c] >>> 24) - 34'(s6_sy[c] >>> 24);
      s6_h[c]  = s6_hll_r[c] + {s6_hlh_r[c] + s6_hhl_r[c], 32'h0};
      s6_hx[c] = s6_h[c] ^ 64'($signed(s6_h[c]) >>> SH);
    end
  end

  always_ff @(posedge clk) begin
    if (en[7]) begin
      for (int c = 0; c < 3; c++) begin
        s7_dx_r[c]   <= s6_dx_r[c];
        s7_dy_r[c]   <= s6_dy_r[c];
        s7_apos_r[c] <= (s6_a[c] > 34'sd0);
        s7_a_r[c]    <= s6_a[c][23:0];
        s7_pair_r[c] <= s6_hx[c][GB:1];
      end
    end
  end

  // stage 8: direction index (pair mod 24) and falloff squared
  logic signed [DW-1:0] s8_dx_r [3];
  logic signed [DW-1:0] s8_dy_r [3];
  logic [2:0]           s8_apos_r;
  logic [4:0]           s8_idx_r [3];
  logic [47:0]          s8_a2p_r [3];
  logic [23:0]          s7_q [3];
  logic [23:0]          s7_r [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      // reciprocal of 24 is exact for pairs below 1024
      s7_q[c] = (24'(s7_pair_r[c]) * 24'd2731) >> 16;
      s7_r[c] = 24'(s7_pair_r[c]) - 24'(s7_q[c] * 24'd24);
    end
  end

  always_ff @(posedge clk) begin
    if (en[8]) begin
      for (int c = 0; c < 3; c++) begin
        s8_dx_r[c]   <= s7_dx_r[c];
        s8_dy_r[c]   <= s7_dy_r[c];
        s8_apos_r[c] <= s7_apos_r[c];
        s8_idx_r[c]  <= s7_r[c][4:0];
        s8_a2p_r[c]  <= 48'(s7_a_r[c]) * 48'(s7_a_r[c]);
      end
    end
  end

  // stage 9: gradient products
  logic [2:0]           s9_apos_r;
  logic [23:0]          s9_a2_r [3];
  logic signed [GW-1:0] s9_gx_r [3];
  logic signed [GW-1:0] s9_gy_r [3];
  sgn2d_pkg::grad_t     s8_g [3];
  logic [47:0]          s8_a2s [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s8_g[c]   = sgn2d_pkg::grad_lookup(s8_idx_r[c]);
      s8_a2s[c] = s8_a2p_r[c] + 48'h80_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en[9]) begin
      for (int c = 0; c < 3; c++) begin
        s9_apos_r[c] <= s8_apos_r[c];
        s9_a2_r[c]   <= s8_a2s[c][47:24];
        s9_gx_r[c]   <= GW'(s8_g[c].gx * s8_dx_r[c]);
        s9_gy_r[c]   <= GW'(s8_g[c].gy * s8_dy_r[c]);
      end
    end
  end

  // stage 10: dot product and falloff to the fourth
  logic [2:0]           s10_apos_r;
  logic [47:0]          s10_a4p_r [3];
  logic signed [OW-1:0] s10_dot_r [3];
  logic signed [GW:0]   s9_dsum [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s9_dsum[c] = (GW+1)'(s9_gx_r[c]) + (GW+1)'(s9_gy_r[c]) + (GW+1)'(64'sd32768);
    end
  end

  always_ff @(posedge clk) begin
    if (en[10]) begin
      for (int c = 0; c < 3; c++) begin
        s10_apos_r[c] <= s9_apos_r[c];
        s10_a4p_r[c]  <= 48'(s9_a2_r[c]) * 48'(s9_a2_r[c]);
        s10_dot_r[c]  <= OW'(s9_dsum[c] >>> 16);
      end
    end
  end

  // stage 11: corner contributions
  logic signed [63:0] s11_term_r [3];
  logic [47:0]        s10_a4s [3];

  always_comb begin
    for (int c = 0; c < 3; c++) begin
      s10_a4s[c] = s10_a4p_r[c] + 48'h80_0000;
    end
  end

  always_ff @(posedge clk) begin
    if (en[11]) begin
      for (int c = 0; c < 3; c++) begin
        if (s10_apos_r[c]) begin
          s11_term_r[c] <= 64'($signed({1'b0, s10_a4s[c][47:24]}) * s10_dot_r[c]);
        end else begin
          s11_term_r[c] <= '0;
        end
      end
    end
  end

  // stage 12: sum, round to q1.16, saturate
  logic signed [63:0] s11_acc;
  logic signed [31:0] s11_v;

  always_comb begin
    s11_acc = s11_term_r[0] + s11_term_r[1] + s11_term_r[2] + 64'sh8000_0000;
    s11_v   = 32'(s11_acc >>> 32);
  end

  always_ff @(posedge clk) begin
    if (en[12]) begin
      priority if (s11_v > 32'(sgn2d_pkg::OUT_MAX)) begin
        out_noise_value <= sgn2d_pkg::OUT_MAX;
      end else if (s11_v < -32'(sgn2d_pkg::OUT_MAX)) begin
        out_noise_value <= -sgn2d_pkg::OUT_MAX;
      end else begin
        out_noise_value <= 18'(s11_v);
      end
    end
  end

  // checks
  `SGN_ASSERT_IMP(a_out_range, clk, rst_n, out_valid, (out_noise_value <= sgn2d_pkg::OUT_MAX) && (out_noise_value >= -sgn2d_pkg::OUT_MAX), "noise value out of range")
  `SGN_ASSERT_IMP(a_full_stall, clk, rst_n, !in_ready, (&v_r) && !out_ready, "request refused while pipe not full")
  `SGN_ASSERT_IMP(a_idx_range, clk, rst_n, v_r[8], (s8_idx_r[0] < 5'd24) && (s8_idx_r[1] < 5'd24) && (s8_idx_r[2] < 5'd24), "direction index past table")

endmodule
`default_nettype wire
